### design/hmc_pkg.sv
// ----------------------------------------------------------------------------
// hmc_pkg
// Shared types and constants for the heat map color mapper.
// ----------------------------------------------------------------------------
package hmc_pkg;

  localparam int FRACTION_BITS_DEF = 16;
  localparam int TEMP_WIDTH_DEF    = 32;
  localparam int CFG_INDEX_W       = 2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_RANGE_LOW  = 2'd0,
    REG_RANGE_HIGH = 2'd1
  } cfg_reg_t;

  localparam logic [63:0] RANGE_LOW_RESET  = 64'd0;
  localparam logic [63:0] RANGE_HIGH_RESET = 64'd65536;

  localparam logic [7:0] CH_MAX = 8'd255;
  localparam logic [7:0] CH_MIN = 8'd0;

  typedef struct packed {
    logic force_en;   // u is fixed at 0 or 1, quotient unused
    logic force_one;
    logic invalid;    // range_high <= range_low
  } hmc_ctrl_t;

endpackage

### design/hmc_in_if.sv
// ----------------------------------------------------------------------------
// hmc_in_if
// Sample channel: valid/ready handshake carrying one temperature.
// ----------------------------------------------------------------------------
interface hmc_in_if #(
  parameter int TEMP_WIDTH = hmc_pkg::TEMP_WIDTH_DEF
);
  logic                  valid;
  logic                  ready;
  logic [TEMP_WIDTH-1:0] temperature;

  modport source (output valid, output temperature, input ready);
  modport sink   (input valid, input temperature, output ready);
endinterface

### design/hmc_out_if.sv
// ----------------------------------------------------------------------------
// hmc_out_if
// Color channel: valid/ready handshake carrying one RGB result.
// ----------------------------------------------------------------------------
interface hmc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       range_invalid;

  modport source (output valid, output red, output green, output blue,
                  output range_invalid, input ready);
  modport sink   (input valid, input red, input green, input blue,
                  input range_invalid, output ready);
endinterface

### design/hmc_front.sv
// ----------------------------------------------------------------------------
// hmc_front
// Forms difference and span, classifies clamp cases, seeds the divider row.
// ----------------------------------------------------------------------------
module hmc_front #(
  parameter int TEMP_WIDTH = hmc_pkg::TEMP_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [TEMP_WIDTH-1:0]  temperature,
  input  logic [TEMP_WIDTH-1:0]  range_low,
  input  logic [TEMP_WIDTH-1:0]  range_high,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [TEMP_WIDTH-1:0]  out_rem,
  output logic [TEMP_WIDTH-1:0]  out_den,
  output hmc_pkg::hmc_ctrl_t     out_ctrl
);
  import hmc_pkg::*;

  logic signed [TEMP_WIDTH:0] t_ext, lo_ext, hi_ext, diff, span;
  logic                       span_pos, diff_pos, diff_ge;
  hmc_ctrl_t                  ctrl_nxt;
  logic                       valid_r;
  logic [TEMP_WIDTH-1:0]      rem_r, den_r;
  hmc_ctrl_t                  ctrl_r;

  always_comb begin
    t_ext    = $signed({temperature[TEMP_WIDTH-1], temperature});
    lo_ext   = $signed({range_low[TEMP_WIDTH-1], range_low});
    hi_ext   = $signed({range_high[TEMP_WIDTH-1], range_high});
    diff     = t_ext - lo_ext;
    span     = hi_ext - lo_ext;
    span_pos = !span[TEMP_WIDTH] && (span != '0);
    diff_pos = !diff[TEMP_WIDTH] && (diff != '0);
    diff_ge  = (diff >= span);
    ctrl_nxt.invalid   = !span_pos;
    ctrl_nxt.force_en  = !span_pos || !diff_pos || diff_ge;
    ctrl_nxt.force_one = span_pos ? diff_ge : diff_pos;
  end

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      rem_r  <= diff[TEMP_WIDTH-1:0];
      den_r  <= span[TEMP_WIDTH-1:0];
      ctrl_r <= ctrl_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_rem   = rem_r;
  assign out_den   = den_r;
  assign out_ctrl  = ctrl_r;

endmodule

### design/hmc_div_cell.sv
// ----------------------------------------------------------------------------
// hmc_div_cell
// One restoring division step: produces one quotient bit per cell.
// ----------------------------------------------------------------------------
module hmc_div_cell #(
  parameter int TEMP_WIDTH    = hmc_pkg::TEMP_WIDTH_DEF,
  parameter int FRACTION_BITS = hmc_pkg::FRACTION_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [TEMP_WIDTH-1:0]    in_rem,
  input  logic [TEMP_WIDTH-1:0]    in_den,
  input  logic [FRACTION_BITS-1:0] in_q,
  input  hmc_pkg::hmc_ctrl_t       in_ctrl,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [TEMP_WIDTH-1:0]    out_rem,
  output logic [TEMP_WIDTH-1:0]    out_den,
  output logic [FRACTION_BITS-1:0] out_q,
  output hmc_pkg::hmc_ctrl_t       out_ctrl
);
  import hmc_pkg::*;

  logic [TEMP_WIDTH:0]        shifted, sub;
  logic                       q_bit;
  logic [TEMP_WIDTH-1:0]      rem_nxt;
  logic                       valid_r;
  logic [TEMP_WIDTH-1:0]      rem_r, den_r;
  logic [FRACTION_BITS-1:0]   q_r;
  hmc_ctrl_t                  ctrl_r;

  always_comb begin
    shifted = {in_rem, 1'b0};
    sub     = shifted - {1'b0, in_den};
    q_bit   = (shifted >= {1'b0, in_den});
    rem_nxt = q_bit ? sub[TEMP_WIDTH-1:0] : shifted[TEMP_WIDTH-1:0];
  end

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      rem_r  <= rem_nxt;
      den_r  <= in_den;
      q_r    <= {in_q[FRACTION_BITS-2:0], q_bit};
      ctrl_r <= in_ctrl;
    end
  end

  assign out_valid = valid_r;
  assign out_rem   = rem_r;
  assign out_den   = den_r;
  assign out_q     = q_r;
  assign out_ctrl  = ctrl_r;

endmodule

### design/hmc_color.sv
// ----------------------------------------------------------------------------
// hmc_color
// Segment select and linear blend; output register of the pipeline.
// ----------------------------------------------------------------------------
module hmc_color #(
  parameter int FRACTION_BITS = hmc_pkg::FRACTION_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [FRACTION_BITS-1:0] in_q,
  input  hmc_pkg::hmc_ctrl_t       in_ctrl,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [7:0]               red,
  output logic [7:0]               green,
  output logic [7:0]               blue,
  output logic                     range_invalid
);
  import hmc_pkg::*;

  localparam int SEG_BITS = FRACTION_BITS - 2;

  localparam logic [2:0] SEG_BLUE_CYAN    = 3'd0;
  localparam logic [2:0] SEG_CYAN_GREEN   = 3'd1;
  localparam logic [2:0] SEG_GREEN_YELLOW = 3'd2;
  localparam logic [2:0] SEG_YELLOW_RED   = 3'd3;

  logic [FRACTION_BITS:0]  u;
  logic [2:0]              seg;
  logic [SEG_BITS-1:0]     pos;
  logic [SEG_BITS+7:0]     prod;
  logic [SEG_BITS+8:0]     prod_ceil;
  logic [7:0]              up, down;
  logic [7:0]              red_nxt, green_nxt, blue_nxt;
  logic                    valid_r;
  logic [7:0]              red_r, green_r, blue_r;
  logic                    invalid_r;

  always_comb begin
    u         = in_ctrl.force_en ? {in_ctrl.force_one, {FRACTION_BITS{1'b0}}}
                                 : {1'b0, in_q};
    seg       = u[FRACTION_BITS:SEG_BITS];
    pos       = u[SEG_BITS-1:0];
    prod      = {pos, 8'd0} - {8'd0, pos};
    prod_ceil = {1'b0, prod} + {9'd0, {SEG_BITS{1'b1}}};
    up        = prod[SEG_BITS+7:SEG_BITS];
    down      = CH_MAX - prod_ceil[SEG_BITS+7:SEG_BITS];
    case (seg)
      SEG_BLUE_CYAN: begin
        red_nxt = CH_MIN; green_nxt = up;     blue_nxt = CH_MAX;
      end
      SEG_CYAN_GREEN: begin
        red_nxt = CH_MIN; green_nxt = CH_MAX; blue_nxt = down;
      end
      SEG_GREEN_YELLOW: begin
        red_nxt = up;     green_nxt = CH_MAX; blue_nxt = CH_MIN;
      end
      SEG_YELLOW_RED: begin
        red_nxt = CH_MAX; green_nxt = down;   blue_nxt = CH_MIN;
      end
      default: begin
        red_nxt = CH_MAX; green_nxt = CH_MIN; blue_nxt = CH_MIN;
      end
    endcase
  end

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      red_r     <= red_nxt;
      green_r   <= green_nxt;
      blue_r    <= blue_nxt;
      invalid_r <= in_ctrl.invalid;
    end
  end

  assign out_valid     = valid_r;
  assign red           = red_r;
  assign green         = green_r;
  assign blue          = blue_r;
  assign range_invalid = invalid_r;

endmodule

### design/heat_map_color_mapper_unit.sv
// ----------------------------------------------------------------------------
// heat_map_color_mapper_unit
// Temperature sample to blue-cyan-green-yellow-red color, fully pipelined.
// ----------------------------------------------------------------------------
// Takes one sample per cycle while the output is not stalled: one front stage
// forms the offset and span, a row of FRACTION_BITS divider cells each
// resolves one quotient bit of the normalized position, and a final stage
// blends the color into the output register. Each stage holds its own valid
// bit, so a stalled result only stops the stages behind it once they fill.
// Range registers must be written only while no transaction is in flight.
// ----------------------------------------------------------------------------
module heat_map_color_mapper_unit #(
  parameter int FRACTION_BITS = hmc_pkg::FRACTION_BITS_DEF,
  parameter int TEMP_WIDTH    = hmc_pkg::TEMP_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  hmc_in_if.sink                           in_if,
  hmc_out_if.source                        out_if,
  input  logic                             cfg_we,
  input  logic [hmc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [TEMP_WIDTH-1:0]            cfg_data
);
  import hmc_pkg::*;

  logic [TEMP_WIDTH-1:0]    range_low_r, range_high_r;

  logic                     valid_a [0:FRACTION_BITS];
  logic                     ready_a [0:FRACTION_BITS];
  logic [TEMP_WIDTH-1:0]    rem_a   [0:FRACTION_BITS];
  logic [TEMP_WIDTH-1:0]    den_a   [0:FRACTION_BITS];
  logic [FRACTION_BITS-1:0] q_a     [0:FRACTION_BITS];
  hmc_ctrl_t                ctrl_a  [0:FRACTION_BITS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_low_r  <= RANGE_LOW_RESET[TEMP_WIDTH-1:0];
      range_high_r <= RANGE_HIGH_RESET[TEMP_WIDTH-1:0];
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RANGE_LOW:  range_low_r  <= cfg_data;
        REG_RANGE_HIGH: range_high_r <= cfg_data;
        default: ;
      endcase
    end
  end

  hmc_front #(
    .TEMP_WIDTH (TEMP_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_if.valid),
    .in_ready    (in_if.ready),
    .temperature (in_if.temperature),
    .range_low   (range_low_r),
    .range_high  (range_high_r),
    .out_valid   (valid_a[0]),
    .out_ready   (ready_a[0]),
    .out_rem     (rem_a[0]),
    .out_den     (den_a[0]),
    .out_ctrl    (ctrl_a[0])
  );

  assign q_a[0] = '0;

  for (genvar i = 0; i < FRACTION_BITS; i++) begin : g_cell
    hmc_div_cell #(
      .TEMP_WIDTH    (TEMP_WIDTH),
      .FRACTION_BITS (FRACTION_BITS)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (valid_a[i]),
      .in_ready  (ready_a[i]),
      .in_rem    (rem_a[i]),
      .in_den    (den_a[i]),
      .in_q      (q_a[i]),
      .in_ctrl   (ctrl_a[i]),
      .out_valid (valid_a[i+1]),
      .out_ready (ready_a[i+1]),
      .out_rem   (rem_a[i+1]),
      .out_den   (den_a[i+1]),
      .out_q     (q_a[i+1]),
      .out_ctrl  (ctrl_a[i+1])
    );
  end

  hmc_color #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_color (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (valid_a[FRACTION_BITS]),
    .in_ready      (ready_a[FRACTION_BITS]),
    .in_q          (q_a[FRACTION_BITS]),
    .in_ctrl       (ctrl_a[FRACTION_BITS]),
    .out_valid     (out_if.valid),
    .out_ready     (out_if.ready),
    .red           (out_if.red),
    .green         (out_if.green),
    .blue          (out_if.blue),
    .range_invalid (out_if.range_invalid)
  );

endmodule

### design/hmc_checker.sv
// ----------------------------------------------------------------------------
// hmc_checker
// Port-level checks on the color channel, bound to the top level.
// ----------------------------------------------------------------------------
module hmc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_red,
  input logic [7:0] out_green,
  input logic [7:0] out_blue,
  input logic       out_range_invalid
);
  import hmc_pkg::*;

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_red) && $stable(out_green)
      && $stable(out_blue) && $stable(out_range_invalid))
    else $error("stalled transaction changed");

  a_red_or_blue_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_red == CH_MIN) || (out_blue == CH_MIN))
    else $error("red and blue both lit");

  a_one_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_red == CH_MAX) || (out_green == CH_MAX) || (out_blue == CH_MAX))
    else $error("no channel at full scale");

endmodule

bind heat_map_color_mapper_unit hmc_checker u_hmc_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_if.valid),
  .out_ready         (out_if.ready),
  .out_red           (out_if.red),
  .out_green         (out_if.green),
  .out_blue          (out_if.blue),
  .out_range_invalid (out_if.range_invalid)
);
